### sv/rmce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmce_pkg
// Shared types, opcodes and constants of the register-memory execute block.
// ----------------------------------------------------------------------------
package rmce_pkg;

  localparam int NUM_REGS_DEF   = 9;
  localparam int DATA_WORDS_DEF = 1024;
  localparam logic [31:0] ADDR_BASE = 32'd16384;
  localparam logic [15:0] PC_STEP   = 16'd4;

  typedef enum logic [3:0] {
    OP_STOP = 4'd0, OP_MOV = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7,
    OP_NOT = 4'd8, OP_CMP = 4'd9, OP_JMP = 4'd10, OP_IN = 4'd11,
    OP_OUT = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0, FAULT_ADDR = 2'd1, FAULT_DIV0 = 2'd2
  } fault_t;

  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd3;

  localparam logic [3:0] JC_ALWAYS = 4'd0;
  localparam logic [3:0] JC_EQ     = 4'd1;
  localparam logic [3:0] JC_GT     = 4'd2;
  localparam logic [3:0] JC_LT     = 4'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDMEM, ST_MEMWAIT, ST_EXEC, ST_MUL, ST_DIV,
    ST_WRITE, ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clr_step;   // write zero at clear address and advance
    logic load;       // capture input beat
    logic mem_rd;     // issue data memory read
    logic mul_go;     // register product
    logic div_start;  // start divider
    logic div_step;   // one divider iteration
    logic commit;     // write back state and form result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic need_mem;   // instruction reads data memory
    logic addr_ok;    // computed address in range
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic div_done;
  } stat_t;

endpackage

### sv/register_memory_cpu_execute_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_memory_cpu_execute_top
// Executes one decoded instruction per input beat and returns one result beat.
// ----------------------------------------------------------------------------
// After reset the block clears its data store, one word a cycle, through
// all DATA_WORDS words (1024 by default), and then raises s_tready.
// An instruction goes from its input beat through operand fetch, a store
// read when needed, execute, multiply or the one-bit-per-cycle divider,
// and commit. One instruction is in work at a time; the next beat is
// taken once the block is idle after a result is registered, and the result
// register lets that beat enter while the last result waits.
module register_memory_cpu_execute_top #(
  parameter int NUM_REGS   = rmce_pkg::NUM_REGS_DEF,
  parameter int DATA_WORDS = rmce_pkg::DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // kind[3:0], dest_reg[7:4], src_sel[11:8],
                                // imm[27:12], in_value[59:28]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // next_pc[15:0], flag[17:16], out_valid[18],
                                // out_value[50:19], fault[52:51]
  output logic        m_tuser   // unused flag slot, zero
);
  import rmce_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  res_set, in_fire, out_free;
  logic [15:0] next_pc;
  logic [1:0]  flag, fault;
  logic        out_valid;
  logic [31:0] out_value;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_set) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  rmce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_ready(s_tready),
    .out_free(out_free), .res_set(res_set), .cmd(cmd), .stat(stat)
  );

  rmce_datapath #(.NUM_REGS(NUM_REGS), .DATA_WORDS(DATA_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .kind(s_tdata[3:0]), .dest_reg(s_tdata[7:4]), .src_sel(s_tdata[11:8]),
    .imm(s_tdata[27:12]), .in_value(s_tdata[59:28]),
    .next_pc(next_pc), .flag(flag), .out_valid(out_valid),
    .out_value(out_value), .fault(fault)
  );

  assign m_tdata = {3'd0, fault, out_value, out_valid, flag, next_pc};
  assign m_tuser = 1'b0;
endmodule

### sv/rmce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmce_ram
// Single-port generic RAM with registered read.
// ----------------------------------------------------------------------------
module rmce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first is not needed; read returns old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### sv/rmce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmce_datapath
// Registers, data store, multiplier and radix-2 divider of the execute block.
// ----------------------------------------------------------------------------
module rmce_datapath #(
  parameter int NUM_REGS   = 9,
  parameter int DATA_WORDS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  rmce_pkg::cmd_t      cmd,
  output rmce_pkg::stat_t     stat,
  input  logic [3:0]          kind,
  input  logic [3:0]          dest_reg,
  input  logic [3:0]          src_sel,
  input  logic signed [15:0]  imm,
  input  logic signed [31:0]  in_value,
  output logic [15:0]         next_pc,
  output logic [1:0]          flag,
  output logic                out_valid,
  output logic [31:0]         out_value,
  output logic [1:0]          fault
);
  import rmce_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  // Captured instruction.
  logic [3:0]  k, rd, rs;
  logic [31:0] immv, inval;

  logic [15:0] pc;
  logic [1:0]  cflag;
  logic [31:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k     <= kind;
      rd    <= dest_reg;
      rs    <= src_sel;
      immv  <= {{16{imm[15]}}, imm};
      inval <= in_value;
    end
  end

  // Register reads; an index beyond the file reads as zero.
  logic [31:0] dv, sv_val;
  always_comb begin
    dv = '0;
    sv_val = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (rd == 4'(i)) dv = regs[i];
      if (rs == 4'(i)) sv_val = regs[i];
    end
  end

  // Address register: destination for stores, source otherwise.
  logic        is_store, is_mem_src;
  logic [31:0] areg, off;
  logic signed [32:0] diff;
  logic        addr_ok;
  always_comb begin
    is_store = (k == OP_MOV) && (rs >= 4'd1) && (rs <= 4'd4);
    areg = is_store ? dv : sv_val;
    diff = $signed({areg[31], areg}) - $signed({1'b0, ADDR_BASE});
    // Truncating halving: add one to negative values before the shift.
    off  = 32'((diff + 33'(diff[32])) >>> 1);
    addr_ok = !off[31] && (off < 32'(DATA_WORDS));
  end

  always_comb begin
    unique case (k)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_CMP, OP_MOV, OP_NOT:
        is_mem_src = (rs != 4'd0);
      default: is_mem_src = 1'b0;
    endcase
  end

  // Data store, shared by clearing sweep and execution.
  logic [AW:0]   clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata, opnd;

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Latched memory word.
  logic [31:0] mword;
  assign opnd = (rs == 4'd0) ? immv : mword;

  // Product register.
  logic [31:0] prod;
  always_ff @(posedge clk) begin
    if (cmd.mul_go) prod <= 32'(dv * opnd);
  end

  // Unsigned restoring divider on magnitudes, one bit per cycle.
  logic [31:0] quo, rem, dvs;
  logic [5:0]  dcnt;
  logic        qneg;
  logic [32:0] trial;
  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      quo  <= dv[31] ? -dv : dv;
      dvs  <= opnd[31] ? -opnd : opnd;
      rem  <= '0;
      qneg <= dv[31] ^ opnd[31];
      dcnt <= 6'd32;
    end else if (cmd.div_step && dcnt != 6'd0) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = off[AW-1:0];
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr[AW-1:0];
    end else if (cmd.commit && addr_ok) begin
      if (is_store) begin
        mem_we = 1'b1;
        mem_wdata = sv_val;
      end else if (k == OP_NOT && rs != 4'd0) begin
        mem_we = 1'b1;
        mem_wdata = {31'd0, mword == 32'd0};
      end
    end
  end

  rmce_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // Capture the read word from the registered RAM output, flagged by rd_pend.
  logic rd_pend;
  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= cmd.mem_rd;
    if (rd_pend) mword <= mem_rdata;
  end

  // Commit: write back and form result.
  logic        wen, taken, mfault;
  logic [31:0] wval;
  logic [1:0]  f;
  always_comb begin
    wen = 1'b0;
    wval = '0;
    f = FAULT_NONE;
    taken = 1'b0;
    mfault = is_mem_src && !addr_ok;
    unique case (k)
      OP_MOV: begin
        if (mfault) f = FAULT_ADDR;
        else if (rs == 4'd0) begin wen = 1'b1; wval = immv; end
        else if (rs >= 4'd5) begin wen = 1'b1; wval = mword; end
      end
      OP_ADD: begin wen = 1'b1; wval = dv + opnd; end
      OP_SUB: begin wen = 1'b1; wval = dv - opnd; end
      OP_MUL: begin wen = 1'b1; wval = prod; end
      OP_DIV: begin
        if (!mfault && opnd == 32'd0) f = FAULT_DIV0;
        else begin wen = 1'b1; wval = qneg ? -quo : quo; end
      end
      OP_AND: begin wen = 1'b1; wval = {31'd0, (dv != 0) && (opnd != 0)}; end
      OP_OR:  begin wen = 1'b1; wval = {31'd0, (dv != 0) || (opnd != 0)}; end
      OP_NOT: begin
        if (rs == 4'd0) begin wen = 1'b1; wval = {31'd0, dv == 32'd0}; end
      end
      OP_JMP: begin
        taken = (rs == JC_ALWAYS) || (rs == JC_EQ && cflag == FLAG_EQ) ||
                (rs == JC_GT && cflag == FLAG_GT) || (rs == JC_LT && cflag == FLAG_LT);
      end
      OP_IN: begin wen = 1'b1; wval = inval; end
      default: ;
    endcase
    if (mfault) begin
      f = FAULT_ADDR;
      wen = 1'b0;
    end else if (f != FAULT_NONE) begin
      wen = 1'b0;
    end
  end

  logic [15:0] pc_next;
  assign pc_next = taken ? pc + immv[15:0] : pc + PC_STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      cflag <= FLAG_EQ;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (cmd.commit) begin
      pc <= pc_next;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (wen && rd == 4'(i)) regs[i] <= wval;
      end
      if (k == OP_CMP && !mfault) begin
        if ($signed(dv) > $signed(opnd))       cflag <= FLAG_GT;
        else if (dv == opnd)                   cflag <= FLAG_EQ;
        else                                   cflag <= FLAG_LT;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_pc   <= pc_next;
      out_valid <= (k == OP_OUT);
      out_value <= (k == OP_OUT) ? dv : 32'd0;
      fault     <= f;
    end
  end
  assign flag = cflag;

  always_comb begin
    stat.clr_done = (clr_addr == (AW+1)'(DATA_WORDS));
    stat.need_mem = is_mem_src;
    stat.addr_ok  = addr_ok;
    stat.is_mul   = (k == OP_MUL);
    stat.is_div   = (k == OP_DIV);
    stat.div_zero = (opnd == 32'd0);
    stat.div_done = (dcnt == 6'd0);
  end

  // A faulting instruction never writes a register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit && f != FAULT_NONE |-> !wen) else $error("fault with write");
  // The divider runs at most 32 steps.
  assert property (@(posedge clk) disable iff (rst)
    dcnt <= 6'd32) else $error("divider count overflow");
  // A clearing write never coincides with an instruction commit.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_step && cmd.commit)) else $error("clear during commit");
endmodule

### sv/rmce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmce_ctrl
// Sequencer: memory clearing sweep, operand fetch, multiply, divide, commit.
// ----------------------------------------------------------------------------
module rmce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  output logic            in_ready,
  input  logic            out_free,
  output logic            res_set,
  output rmce_pkg::cmd_t  cmd,
  input  rmce_pkg::stat_t stat
);
  import rmce_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_set = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clr_done) state_next = ST_IDLE;
        else cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_RDMEM;
        end
      end
      ST_RDMEM: begin
        if (stat.need_mem && stat.addr_ok) begin
          cmd.mem_rd = 1'b1;
          state_next = ST_MEMWAIT;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_MEMWAIT: state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.is_mul) begin
          cmd.mul_go = 1'b1;
          state_next = ST_WRITE;
        end else if (stat.is_div && !stat.div_zero) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_MUL: state_next = ST_WRITE;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          res_set = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Input is taken only when idle.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("beat taken while busy");
  // Every commit returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE) else $error("commit without idle");
  // Clearing precedes any accepted beat.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("ready during clear");
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register-memory execute block testbench
// Drives decoded instructions into the block and checks every result beat
// against a cycle-free model of the machine kept inside a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
  import rmce_pkg::*;

  localparam int NREGS  = 9;
  localparam int NWORDS = 1024;

  // Expected result of one instruction.
  typedef struct packed {
    logic [15:0] next_pc;
    logic [1:0]  flag;
    logic        out_valid;
    logic [31:0] out_value;
    logic [1:0]  fault;
  } result_t;

  // Machine model and queue of pending results.
  class exec_scoreboard;
    logic [15:0] pc;
    logic [1:0]  cflag;
    logic [31:0] regs [NREGS];
    logic [31:0] mem [NWORDS];
    result_t     pending [$];
    int          errors;
    int          checked;

    function new();
      pc = '0;
      cflag = FLAG_EQ;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] rd_reg(logic [3:0] idx);
      return (idx < NREGS) ? regs[idx] : 32'd0;
    endfunction

    function void wr_reg(logic [3:0] idx, logic [31:0] v);
      if (idx < NREGS) regs[idx] = v;
    endfunction

    // Word index from a register value; -1 when out of range.
    function int word_index(logic [31:0] v);
      longint off;
      off = (longint'($signed(v)) - 16384) / 2;
      if (off < 0 || off >= NWORDS) return -1;
      return int'(off);
    endfunction

    function void note_instr(logic [63:0] beat);
      logic [3:0]  op, rd, rs;
      logic [31:0] immv, inval, dv, opnd;
      logic [15:0] npc;
      logic [1:0]  flt;
      logic        ov;
      logic [31:0] oval;
      int          ix;
      longint      q;
      result_t     r;
      op = beat[3:0];
      rd = beat[7:4];
      rs = beat[11:8];
      immv = {{16{beat[27]}}, beat[27:12]};
      inval = beat[59:28];
      dv = rd_reg(rd);
      opnd = immv;
      npc = pc + PC_STEP;
      flt = FAULT_NONE;
      ov = 1'b0;
      oval = '0;
      if (((op >= OP_ADD && op <= OP_OR) || op == OP_CMP) && rs != 0) begin
        ix = word_index(rd_reg(rs));
        if (ix < 0) flt = FAULT_ADDR;
        else opnd = mem[ix];
      end
      case (op)
        OP_MOV: begin
          if (rs == 0) begin
            wr_reg(rd, immv);
          end else if (rs >= 5) begin
            ix = word_index(rd_reg(rs));
            if (ix < 0) flt = FAULT_ADDR;
            else wr_reg(rd, mem[ix]);
          end else begin
            ix = word_index(dv);
            if (ix < 0) flt = FAULT_ADDR;
            else mem[ix] = rd_reg(rs);
          end
        end
        OP_ADD: if (flt == FAULT_NONE) wr_reg(rd, dv + opnd);
        OP_SUB: if (flt == FAULT_NONE) wr_reg(rd, dv - opnd);
        OP_MUL: if (flt == FAULT_NONE) wr_reg(rd, dv * opnd);
        OP_DIV: begin
          if (flt == FAULT_NONE) begin
            if (opnd == 0) begin
              flt = FAULT_DIV0;
            end else begin
              q = longint'($signed(dv)) / longint'($signed(opnd));
              wr_reg(rd, q[31:0]);
            end
          end
        end
        OP_AND: if (flt == FAULT_NONE) wr_reg(rd, {31'd0, (dv != 0) && (opnd != 0)});
        OP_OR:  if (flt == FAULT_NONE) wr_reg(rd, {31'd0, (dv != 0) || (opnd != 0)});
        OP_NOT: begin
          if (rs == 0) begin
            wr_reg(rd, {31'd0, dv == 0});
          end else begin
            ix = word_index(rd_reg(rs));
            if (ix < 0) flt = FAULT_ADDR;
            else mem[ix] = {31'd0, mem[ix] == 0};
          end
        end
        OP_CMP: begin
          if (flt == FAULT_NONE) begin
            if ($signed(dv) > $signed(opnd)) cflag = FLAG_GT;
            else if (dv == opnd) cflag = FLAG_EQ;
            else cflag = FLAG_LT;
          end
        end
        OP_JMP: begin
          if (rs == JC_ALWAYS || (rs == JC_EQ && cflag == FLAG_EQ) ||
              (rs == JC_GT && cflag == FLAG_GT) || (rs == JC_LT && cflag == FLAG_LT))
            npc = pc + immv[15:0];
        end
        OP_IN: wr_reg(rd, inval);
        OP_OUT: begin
          ov = 1'b1;
          oval = dv;
        end
        default: ;
      endcase
      pc = npc;
      r.next_pc = npc;
      r.flag = cflag;
      r.out_valid = ov;
      r.out_value = oval;
      r.fault = flt;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %h, expected %h", checked, what, got, want);
    endtask

    task check_result(logic [55:0] data);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", data[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      if (data[15:0] != e.next_pc)
        report("next_pc", 32'(data[15:0]), 32'(e.next_pc));
      if (data[17:16] != e.flag)
        report("flag", 32'(data[17:16]), 32'(e.flag));
      if (data[18] != e.out_valid)
        report("out_valid", 32'(data[18]), 32'(e.out_valid));
      if (data[50:19] != e.out_value)
        report("out_value", data[50:19], e.out_value);
      if (data[52:51] != e.fault)
        report("fault", 32'(data[52:51]), 32'(e.fault));
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  exec_scoreboard sb;
  bit  calm;
  int  sent;

  register_memory_cpu_execute_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Accepted beats on both sides go to the scoreboard.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_instr(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Result side stalls in random bursts.
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(negedge clk);
    end
  end

  // Presents one beat and returns at the falling edge after it is taken;
  // tvalid stays up so the next beat can follow without a gap.
  task automatic send_instr(op_t op, logic [3:0] rd, logic [3:0] rs,
                            logic [15:0] imm, logic [31:0] inval);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 14);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, inval, imm, rs, rd, 4'(op)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Address register values: mostly in range, sometimes just outside.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 32'd16382;
      1: return 32'd16384 + 2 * NWORDS;
      2: return 32'd16383 - 2 * $urandom_range(0, 3);
      3: return $urandom();
      default: return 32'd16384 + $urandom_range(0, 2 * NWORDS - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 9);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int   k;
    op_t  op;
    logic [3:0] rs;
    sb = new();
    calm = 1'b0;
    sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: limits, each operation but STOP and the special cases.
    send_instr(OP_IN, 4'd1, 4'd0, 16'd0, 32'h8000_0000);
    send_instr(OP_IN, 4'd2, 4'd0, 16'd0, 32'hFFFF_FFFF);
    send_instr(OP_DIV, 4'd1, 4'd2, 16'd0, 32'd0);          // address fault first
    send_instr(OP_MOV, 4'd2, 4'd0, 16'hFFFF, 32'd0);
    send_instr(OP_DIV, 4'd1, 4'd0, 16'hFFFF, 32'd0);       // min / -1 wraps
    send_instr(OP_DIV, 4'd1, 4'd0, 16'd0, 32'd0);          // divide by zero
    send_instr(OP_MOV, 4'd3, 4'd0, 16'h4000, 32'd0);
    send_instr(OP_MOV, 4'd3, 4'd1, 16'd0, 32'd0);          // store to word 0
    send_instr(OP_MOV, 4'd5, 4'd0, 16'h7FFF, 32'd0);
    send_instr(OP_ADD, 4'd5, 4'd0, 16'h7FFF, 32'd0);
    send_instr(OP_MOV, 4'd6, 4'd3, 16'd0, 32'd0);
    send_instr(OP_MOV, 4'd7, 4'd6, 16'd0, 32'd0);          // load via register 6
    send_instr(OP_MUL, 4'd2, 4'd0, 16'h8000, 32'd0);
    send_instr(OP_SUB, 4'd1, 4'd3, 16'd0, 32'd0);
    send_instr(OP_AND, 4'd1, 4'd0, 16'd0, 32'd0);
    send_instr(OP_OR, 4'd4, 4'd0, 16'd1, 32'd0);
    send_instr(OP_NOT, 4'd4, 4'd0, 16'd0, 32'd0);
    send_instr(OP_NOT, 4'd0, 4'd3, 16'd0, 32'd0);          // invert memory word
    send_instr(OP_CMP, 4'd2, 4'd0, 16'd5, 32'd0);
    send_instr(OP_JMP, 4'd0, JC_LT, 16'h8000, 32'd0);
    send_instr(OP_JMP, 4'd0, 4'd7, 16'h0010, 32'd0);        // unknown condition
    send_instr(OP_OUT, 4'd8, 4'd15, 16'd0, 32'd0);
    send_instr(OP_IN, 4'd15, 4'd0, 16'd0, 32'h1234_5678);  // register out of range
    send_instr(OP_OUT, 4'd15, 4'd0, 16'd0, 32'd0);
    send_instr(op_t'(4'd14), 4'd15, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    s_tvalid <= 1'b0;

    // Drain completely once before the random part.
    while (sb.pending.size() != 0) @(negedge clk);

    // Random: mostly sensible programs, with some noise.
    for (k = 0; k < 750; k++) begin
      if (k == 650) calm = 1'b1;
      rs = 4'($urandom_range(0, 8));
      case ($urandom_range(0, 15))
        0: send_instr(OP_IN, 4'($urandom_range(0, 8)), 4'd0, 16'($urandom()), pick_addr());
        1: send_instr(OP_IN, 4'($urandom_range(0, 8)), 4'd0, 16'($urandom()), pick_val());
        2: send_instr(OP_MOV, 4'($urandom_range(0, 8)), rs, 16'($urandom()), $urandom());
        3: send_instr(OP_JMP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 5)),
                      16'($urandom()), $urandom());
        4: send_instr(op_t'(4'($urandom_range(0, 15))), 4'($urandom()), 4'($urandom()),
                      16'($urandom()), $urandom());
        5: send_instr(OP_OUT, 4'($urandom_range(0, 9)), rs, 16'($urandom()), $urandom());
        default: begin
          op = op_t'(4'($urandom_range(0, 12)));
          send_instr(op, 4'($urandom_range(0, 8)), ($urandom_range(0, 2) == 0) ? 4'd0 : rs,
                     ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom()),
                     $urandom());
        end
      endcase
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Ran %0d instructions, %0d results checked, all opcodes with faults and jumps.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Timeout after %0d instructions.", sent);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
